@@ rtl/core/mwo_pkg.sv @@
// Shared types, constants and the quarter-sine table function for the oscillator.
`timescale 1ns / 1ps
package mwo_pkg;

  // Default sizes for the top-level parameters
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Field widths
  localparam int STEP_W   = 32;
  localparam int T_W      = 32;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int AMP_W    = 15;
  localparam int DUTY_W   = 4;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd28000;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 4'd3;

  // Full-scale magnitude of a shape (+1.0)
  localparam logic [MAG_W-1:0] FULL_SCALE = 16'h8000;

  // pi/2 in Q30, used to build the quarter-wave table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Reciprocals of the series divisors (2n)(2n+1), rounded up; the product
  // shifted down by RECIP_SHIFT gives the exact floor quotient for every
  // dividend below 2^39, and the series never goes past 2^33
  localparam int RECIP_SHIFT = 48;
  localparam logic [8:1][47:0] TAYLOR_RECIP = {
    48'(((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272),
    48'(((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210),
    48'(((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156),
    48'(((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110),
    48'(((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72),
    48'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42),
    48'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20),
    48'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6)
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVEFORM_MODE = 2'd0,
    REG_AMPLITUDE     = 2'd1,
    REG_DUTY_TENTHS   = 2'd2
  } reg_index_t;

  // Waveform codes
  typedef enum logic [MODE_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_SAWTOOTH = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_PULSE    = 3'd4
  } wave_mode_t;

  // Shape stage result, sign and magnitude form
  typedef struct packed {
    logic             active;   // mode produces a waveform
    logic             is_sine;  // magnitude comes from the table read
    logic             neg;
    logic [MAG_W-1:0] mag;
  } shape_t;

  // One quarter-sine entry: fixed-point Q30 Taylor series, rounded to Q15
  function automatic logic [MAG_W-1:0] sine_entry(input logic [31:0] k, input int tb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    logic [127:0]       prod;
    x    = (HALF_PI_Q30 * 64'(k)) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      prod = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[n]);
      term = prod[RECIP_SHIFT+63:RECIP_SHIFT];
      if (n[0]) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    v = (unsigned'(acc) + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

@@ rtl/core/mwo_phase.sv @@
// Input stage: phase accumulator and captured phase of the accepted transaction.
`timescale 1ns / 1ps
module mwo_phase #(
  parameter int PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic                        in_valid,
  input  logic                        command,
  input  logic [mwo_pkg::STEP_W-1:0]  phase_step,
  output logic                        valid,
  output logic [mwo_pkg::T_W-1:0]     t32
);
  import mwo_pkg::*;

  logic [PHASE_BITS-1:0]        phase;
  logic [PHASE_BITS-1:0]        phase_cur;
  logic [PHASE_BITS-1:0]        step_al;
  logic [PHASE_BITS+STEP_W-1:0] step_wide;
  logic [PHASE_BITS+T_W-1:0]    phase_wide;

  // Clear the phase on a note start, then align to the top 32 bits
  assign phase_cur  = command ? '0 : phase;
  assign phase_wide = {phase_cur, {T_W{1'b0}}};
  assign step_wide  = {phase_step, {PHASE_BITS{1'b0}}};
  assign step_al    = step_wide[PHASE_BITS+STEP_W-1:STEP_W];

  // Advance the accumulator on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_valid;
      if (in_valid) begin
        phase <= phase_cur + step_al;
      end
    end
  end

  // Capture the phase the sample is taken at
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      t32 <= phase_wide[PHASE_BITS+T_W-1:PHASE_BITS];
    end
  end

endmodule

@@ rtl/core/mwo_shape.sv @@
// Shape stage: quarter-sine ROM read and the arithmetic waveforms.
`timescale 1ns / 1ps
module mwo_shape #(
  parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic                        in_valid,
  input  logic [mwo_pkg::T_W-1:0]     t32,
  input  logic [mwo_pkg::MODE_W-1:0]  waveform_mode,
  input  logic [mwo_pkg::DUTY_W-1:0]  duty_tenths,
  output logic                        valid,
  output mwo_pkg::shape_t             shape,
  output logic [mwo_pkg::MAG_W-1:0]   rom_data
);
  import mwo_pkg::*;

  localparam int QLEN = (1 << SINE_TABLE_BITS) + 1;
  localparam int AW   = SINE_TABLE_BITS + 1;

  typedef logic [MAG_W-1:0] qtab_t [QLEN];

  function automatic qtab_t build_table();
    qtab_t t;
    for (int k = 0; k < QLEN; k++) begin
      t[k] = sine_entry(32'(k), SINE_TABLE_BITS);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_table();

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [AW-1:0]              addr;
  logic [15:0]                saw_u;
  logic [31:0]                tri_d;
  logic [16:0]                tri_e;
  logic [35:0]                t_x10;
  logic [35:0]                duty_lim;
  shape_t                     shape_next;
  logic                       load;

  assign load = take && in_valid;

  // Quadrant select and mirrored table address
  assign quad = t32[T_W-1:T_W-2];
  assign idx  = t32[T_W-3 -: SINE_TABLE_BITS];
  assign addr = quad[0] ? (AW'(1 << SINE_TABLE_BITS) - {1'b0, idx}) : {1'b0, idx};

  // Helpers for sawtooth, triangle and pulse
  assign saw_u    = t32[T_W-1:T_W-16];
  assign tri_d    = t32[T_W-1] ? {1'b0, t32[T_W-2:0]} : (32'h8000_0000 - t32);
  assign tri_e    = tri_d[31:15];
  assign t_x10    = 36'({t32, 3'b000}) + 36'({t32, 1'b0});
  assign duty_lim = {duty_tenths, 32'h0000_0000};

  // Select the shape as sign and magnitude
  always_comb begin
    shape_next        = '0;
    shape_next.active = 1'b1;
    case (waveform_mode)
      WAVE_SINE: begin
        shape_next.is_sine = 1'b1;
        shape_next.neg     = quad[1];
      end
      WAVE_SQUARE: begin
        shape_next.neg = t32[T_W-1];
        shape_next.mag = FULL_SCALE;
      end
      WAVE_SAWTOOTH: begin
        shape_next.neg = saw_u[15];
        shape_next.mag = saw_u[15] ? (16'd0 - saw_u) : saw_u;
      end
      WAVE_TRIANGLE: begin
        if (tri_e >= 17'd32768) begin
          shape_next.neg = 1'b0;
          shape_next.mag = 16'(tri_e - 17'd32768);
        end else begin
          shape_next.neg = 1'b1;
          shape_next.mag = 16'(17'd32768 - tri_e);
        end
      end
      WAVE_PULSE: begin
        shape_next.neg = !(t_x10 < duty_lim);
        shape_next.mag = FULL_SCALE;
      end
      default: begin
        shape_next.active = 1'b0;
      end
    endcase
  end

  // Hold valid across stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_valid;
    end
  end

  // Register the shape and the ROM read together
  always_ff @(posedge clk) begin
    if (load) begin
      shape    <= shape_next;
      rom_data <= QTAB[addr];
    end
  end

endmodule

@@ rtl/core/mwo_scale.sv @@
// Output stage: amplitude scaling with truncation toward zero.
`timescale 1ns / 1ps
module mwo_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          in_valid,
  input  mwo_pkg::shape_t               shape,
  input  logic [mwo_pkg::MAG_W-1:0]     rom_data,
  input  logic [mwo_pkg::AMP_W-1:0]     amplitude,
  output logic                          valid,
  output logic signed [mwo_pkg::SAMPLE_W-1:0] sample
);
  import mwo_pkg::*;

  logic [MAG_W-1:0]          mag;
  logic [AMP_W+MAG_W-1:0]    prod;
  logic [SAMPLE_W-1:0]       scaled;
  logic [SAMPLE_W-1:0]       sample_next;

  // Scale the magnitude, then restore the sign
  assign mag    = shape.is_sine ? rom_data : shape.mag;
  assign prod   = (AMP_W + MAG_W)'(amplitude) * (AMP_W + MAG_W)'(mag);
  assign scaled = prod[AMP_W+MAG_W-1:15];

  always_comb begin
    if (!shape.active) begin
      sample_next = '0;
    end else if (shape.neg) begin
      sample_next = '0 - scaled;
    end else begin
      sample_next = scaled;
    end
  end

  // Hold valid across stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      sample <= signed'(sample_next);
    end
  end

endmodule

@@ rtl/core/multi_waveform_oscillator.sv @@
// Top level of the phase-accumulator waveform oscillator.
//
//   channel   direction  handshake                   payload
//   step      in         step_valid / step_ready     command, phase_step
//   sample    out        sample_valid / sample_ready sample
//   config    in         cfg_write                   cfg_index, cfg_data
//
// Three-stage pipeline: phase register, shape register with the quarter-sine
// ROM read, output register after the amplitude multiply. One transaction is
// taken per cycle unless a stalled output holds the pipeline; a step
// passes through the phase, shape and output registers before its sample is valid.
// A stalled output holds each stage that is full; empty stages keep filling.
// Reset clears the phase and the valid bits and loads the register defaults.
`timescale 1ns / 1ps
module multi_waveform_oscillator #(
  parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 step_valid,
  output logic                                 step_ready,
  input  logic                                 command,
  input  logic [mwo_pkg::STEP_W-1:0]           phase_step,
  output logic                                 sample_valid,
  input  logic                                 sample_ready,
  output logic signed [mwo_pkg::SAMPLE_W-1:0]  sample
);
  import mwo_pkg::*;

  logic [MODE_W-1:0] waveform_mode;
  logic [AMP_W-1:0]  amplitude;
  logic [DUTY_W-1:0] duty_tenths;

  logic             v1;
  logic             v2;
  logic             take1;
  logic             take2;
  logic             take3;
  logic [T_W-1:0]   t32;
  shape_t           shape;
  logic [MAG_W-1:0] rom_data;

  // A stage loads when it is empty or its content moves on
  assign take3      = !sample_valid || sample_ready;
  assign take2      = !v2 || take3;
  assign take1      = !v1 || take2;
  assign step_ready = take1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_mode <= MODE_RESET;
      amplitude     <= AMP_RESET;
      duty_tenths   <= DUTY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WAVEFORM_MODE: waveform_mode <= cfg_data[MODE_W-1:0];
        REG_AMPLITUDE:     amplitude     <= cfg_data[AMP_W-1:0];
        REG_DUTY_TENTHS:   duty_tenths   <= cfg_data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mwo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst        (rst),
    .take       (take1),
    .in_valid   (step_valid),
    .command    (command),
    .phase_step (phase_step),
    .valid      (v1),
    .t32        (t32)
  );

  mwo_shape #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shape (
    .clk           (clk),
    .rst           (rst),
    .take          (take2),
    .in_valid      (v1),
    .t32           (t32),
    .waveform_mode (waveform_mode),
    .duty_tenths   (duty_tenths),
    .valid         (v2),
    .shape         (shape),
    .rom_data      (rom_data)
  );

  mwo_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .take      (take3),
    .in_valid  (v2),
    .shape     (shape),
    .rom_data  (rom_data),
    .amplitude (amplitude),
    .valid     (sample_valid),
    .sample    (sample)
  );

endmodule
